/* hdl/mse_pkg.sv */
// Shared types and constants for the MIPS integer subset execute block.
// No dependencies; used by mse_exec and mips_subset_instruction_execute.
`timescale 1ns / 1ps

package mse_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;

  localparam reg_idx_t REG_ZERO = 5'd0;
  localparam reg_idx_t REG_V0   = 5'd2;
  localparam reg_idx_t REG_RA   = 5'd31;

  localparam word_t EXIT_CODE      = 32'd10;
  localparam word_t PC_STEP        = 32'd4;
  localparam word_t START_PC_RESET = 32'h0040_0000;

  // Retire information for one instruction
  typedef struct packed {
    word_t    next_pc;
    logic     we;
    reg_idx_t widx;
    word_t    wval;
    logic     halt_set;
  } exec_result_t;

endpackage

/* hdl/mse_exec.sv */
// Decode and execute logic for one instruction (purely combinational).
// Depends on mse_pkg for opcodes, funct codes and the result struct.
`timescale 1ns / 1ps

module mse_exec (
  input  mse_pkg::word_t        instr,
  input  mse_pkg::word_t        pc,
  input  mse_pkg::word_t        rs_val,
  input  mse_pkg::word_t        rt_val,
  input  mse_pkg::word_t        v0_val,
  input  logic                  halted,
  output mse_pkg::exec_result_t res
);

  logic [5:0]        opcode;
  logic [5:0]        funct;
  mse_pkg::reg_idx_t rt_idx;
  mse_pkg::reg_idx_t rd_idx;
  mse_pkg::word_t    imm_ext;
  mse_pkg::word_t    pc_plus4;
  mse_pkg::word_t    jump_target;
  logic              wr;
  mse_pkg::reg_idx_t wr_idx;
  mse_pkg::word_t    wr_val;

  assign opcode      = instr[31:26];
  assign funct       = instr[5:0];
  assign rt_idx      = instr[20:16];
  assign rd_idx      = instr[15:11];
  assign imm_ext     = {{16{instr[15]}}, instr[15:0]};
  assign pc_plus4    = pc + mse_pkg::PC_STEP;
  // top nibble of the current PC, then the 26-bit word target
  assign jump_target = {pc[31:28], instr[25:0], 2'b00};

  always_comb begin
    res          = '0;
    res.next_pc  = pc_plus4;
    wr           = 1'b0;
    wr_idx       = mse_pkg::REG_ZERO;
    wr_val       = '0;
    if (halted) begin
      res.next_pc = pc;
    end else begin
      unique case (opcode)
        mse_pkg::OP_SPECIAL: begin
          unique case (funct)
            mse_pkg::FN_AND: begin
              wr = 1'b1; wr_idx = rd_idx; wr_val = rs_val & rt_val;
            end
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: begin
              wr = 1'b1; wr_idx = rd_idx; wr_val = rs_val - rt_val;
            end
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: begin
              wr = 1'b1; wr_idx = rd_idx; wr_val = rs_val + rt_val;
            end
            mse_pkg::FN_SYSCALL: begin
              res.halt_set = (v0_val == mse_pkg::EXIT_CODE);
            end
            default: ;
          endcase
        end
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
          wr = 1'b1; wr_idx = rt_idx; wr_val = rs_val + imm_ext;
        end
        mse_pkg::OP_J: begin
          res.next_pc = jump_target;
        end
        mse_pkg::OP_JAL: begin
          res.next_pc = jump_target;
          wr = 1'b1; wr_idx = mse_pkg::REG_RA; wr_val = pc_plus4;
        end
        default: ;
      endcase
    end
    // $zero is never written
    if (wr && (wr_idx != mse_pkg::REG_ZERO)) begin
      res.we   = 1'b1;
      res.widx = wr_idx;
      res.wval = wr_val;
    end
  end

endmodule

/* hdl/mips_subset_instruction_execute.sv */
// Top level of the MIPS integer subset execute block.
// Depends on mse_pkg and mse_exec.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready, instr_word): one request per fetched
//   instruction word at the current PC. Output channel (out_valid/out_ready):
//   one result per request with next_pc, the write-back (write_enable,
//   write_index, write_value) and the halt flag.
//   Config channel (cfg_valid/cfg_ready, cfg_data): start_pc. Always ready.
//   start_pc returns to 0x0040_0000 at every reset, so a write leaves no
//   visible state.
// Timing
//   The accept edge registers the word and the two register file reads; the
//   commit edge registers the result. Throughput one request per cycle while
//   out_ready is high. The register file write of one instruction and the
//   read of the next share an edge, so that read is bypassed.
// Reset
//   Synchronous: PC = 0x0040_0000, halt clear, every register reads as zero
//   (per-entry valid bits, no clearing pass), pipeline empty.
// Stall
//   While out_ready is low, the result holds; one more request may sit in
//   the execute stage, after which in_ready drops. After an exit syscall,
//   requests are still taken and answered with the unchanged PC and halt.

module mips_subset_instruction_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [31:0] write_value,
  output logic        halt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // Register file storage: two read ports (rs, rt), one write port
  mse_pkg::word_t rf_mem [32];
  logic [31:0]    rf_valid;

  // Execute stage
  logic              ex_valid;
  mse_pkg::word_t    ex_instr;
  mse_pkg::word_t    rd_a;
  mse_pkg::word_t    rd_b;
  logic              a_vld;
  logic              b_vld;
  logic              a_fwd;
  logic              b_fwd;
  mse_pkg::word_t    fwd_val;

  // Architectural state
  mse_pkg::word_t    pc;
  logic              halted;
  mse_pkg::word_t    v0;     // copy of register 2 for the syscall check

  logic                  in_fire;
  logic                  commit;
  logic                  wb_hit;
  mse_pkg::reg_idx_t     rs_in;
  mse_pkg::reg_idx_t     rt_in;
  mse_pkg::word_t        a_op;
  mse_pkg::word_t        b_op;
  mse_pkg::exec_result_t res;

  assign rs_in    = instr_word[25:21];
  assign rt_in    = instr_word[20:16];
  assign commit   = ex_valid && (!out_valid || out_ready);
  assign in_ready = !ex_valid || commit;
  assign in_fire  = in_valid && in_ready;
  assign wb_hit   = commit && res.we;

  // start_pc has no state that outlives reset; writes are simply taken
  assign cfg_ready = 1'b1;

  assign a_op = a_fwd ? fwd_val : (a_vld ? rd_a : '0);
  assign b_op = b_fwd ? fwd_val : (b_vld ? rd_b : '0);

  mse_exec u_exec (
    .instr  (ex_instr),
    .pc     (pc),
    .rs_val (a_op),
    .rt_val (b_op),
    .v0_val (v0),
    .halted (halted),
    .res    (res)
  );

  // Register file array: write-back and registered reads
  always_ff @(posedge clk) begin
    if (wb_hit) begin
      rf_mem[res.widx] <= res.wval;
    end
    if (in_fire) begin
      rd_a <= rf_mem[rs_in];
      rd_b <= rf_mem[rt_in];
    end
  end

  // Execute stage payload, with bypass of the write retiring this edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_instr <= instr_word;
      a_vld    <= rf_valid[rs_in];
      b_vld    <= rf_valid[rt_in];
      a_fwd    <= wb_hit && (res.widx == rs_in);
      b_fwd    <= wb_hit && (res.widx == rt_in);
      fwd_val  <= res.wval;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      rf_valid  <= '0;
      pc        <= mse_pkg::START_PC_RESET;
      halted    <= 1'b0;
      v0        <= '0;
    end else begin
      if (in_fire) begin
        ex_valid <= 1'b1;
      end else if (commit) begin
        ex_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        pc     <= res.next_pc;
        halted <= halted | res.halt_set;
      end
      if (wb_hit) begin
        rf_valid[res.widx] <= 1'b1;
        if (res.widx == mse_pkg::REG_V0) begin
          v0 <= res.wval;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      next_pc      <= res.next_pc;
      write_enable <= res.we;
      write_index  <= res.widx;
      write_value  <= res.wval;
      halt         <= halted | res.halt_set;
    end
  end

endmodule
